// ----- hw/rtl/cgpc_pkg.sv -----
// shared constants and types for the chroma gaussian pixel classifier
package cgpc_pkg;

   // fixed field widths
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 32;
   localparam int SCORE_W    = 48;
   localparam int SUM_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // control register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN_R    = 3'd0,
      CSR_MEAN_G    = 3'd1,
      CSR_COEF_RR   = 3'd2,
      CSR_COEF_RG   = 3'd3,
      CSR_COEF_GG   = 3'd4,
      CSR_THRESHOLD = 3'd5
   } csr_reg_type;

endpackage

// ----- hw/rtl/cgpc_if.sv -----
// pixel request and classification response channels

// pixel word, source drives valid and payload, sink drives ready
interface cgpc_req_if import cgpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// classification word, chroma width follows the fraction bits
interface cgpc_rsp_if import cgpc_pkg::*; #(parameter int FRAC_BITS = 16) ();
   logic                      valid;
   logic                      ready;
   logic [FRAC_BITS:0]        chroma_r;
   logic [FRAC_BITS:0]        chroma_g;
   logic signed [SCORE_W-1:0] score;
   logic                      match;
   logic                      valid_res;

   modport source (output valid, output chroma_r, output chroma_g, output score,
                   output match, output valid_res, input ready);
   modport sink   (input valid, input chroma_r, input chroma_g, input score,
                   input match, input valid_res, output ready);
endinterface

// ----- hw/rtl/chroma_gaussian_pixel_classifier_unit.sv -----
// rg chromaticity gaussian colour classifier, fully pipelined top level
//
//   channel    | direction | handshake          | word
//   req_chan   | in        | valid/ready        | red, green, blue (8 bits each)
//   rsp_chan   | out       | valid/ready        | chroma_r, chroma_g, score, match, valid_res
//   csr_*      | in        | write enable only  | index (3 bits), data (48 bits)
//
// one pixel per clock while the response channel is not stalled; latency comes from the
// restoring divider (one quotient bit per stage) plus the multiply chain
// synchronous active-high reset clears the valid bits and the control registers
// a stalled response freezes every stage together, so no word is lost or repeated
module chroma_gaussian_pixel_classifier_unit import cgpc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   cgpc_req_if.sink              req_chan,
   cgpc_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CW    = FRAC_BITS + 1;       // chroma width
   localparam int REM_W = SUM_W;               // remainder stays below the sum
   localparam int DW    = FRAC_BITS + 2;       // deviation width, signed
   localparam int PW    = 2 * DW;              // deviation product width
   localparam int LO_W  = DW;                  // low slice of a product
   localparam int HI_W  = PW - LO_W;           // high slice, signed
   localparam int LP_W  = LO_W + 1 + COEF_W;   // low partial product width
   localparam int HP_W  = HI_W + COEF_W;       // high partial product width
   localparam int TW    = PW + COEF_W;         // one weighted term
   localparam int AW    = TW + 2;              // sum of three terms
   localparam int SHIFT = 2 * FRAC_BITS;

   // control registers
   logic [CW-1:0]             mean_r_ff, mean_g_ff;
   logic signed [COEF_W-1:0]  coef_rr_ff, coef_rg_ff, coef_gg_ff;
   logic signed [SCORE_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_r_ff  <= '0;
         mean_g_ff  <= '0;
         coef_rr_ff <= '0;
         coef_rg_ff <= '0;
         coef_gg_ff <= '0;
         thr_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            CSR_MEAN_R:    mean_r_ff  <= csr_wr_data[CW-1:0];
            CSR_MEAN_G:    mean_g_ff  <= csr_wr_data[CW-1:0];
            CSR_COEF_RR:   coef_rr_ff <= $signed(csr_wr_data[COEF_W-1:0]);
            CSR_COEF_RG:   coef_rg_ff <= $signed(csr_wr_data[COEF_W-1:0]);
            CSR_COEF_GG:   coef_gg_ff <= $signed(csr_wr_data[COEF_W-1:0]);
            CSR_THRESHOLD: thr_ff     <= $signed(csr_wr_data[SCORE_W-1:0]);
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the output word is held
   logic adv;
   logic rsp_v_ff;
   logic in_acc;

   assign adv            = !rsp_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign in_acc         = req_chan.valid && adv;

   // divider pipe, index 0 is the input register, index CW holds full quotients
   logic [REM_W-1:0] rem_r_ff [0:CW];
   logic [REM_W-1:0] rem_g_ff [0:CW];
   logic [SUM_W-1:0] sum_ff   [0:CW];
   logic [CW-1:0]    quo_r_ff [1:CW];
   logic [CW-1:0]    quo_g_ff [1:CW];
   logic             dv_ff    [0:CW];

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_r_ff[0] <= REM_W'(req_chan.red);
         rem_g_ff[0] <= REM_W'(req_chan.green);
         sum_ff[0]   <= SUM_W'(req_chan.red) + SUM_W'(req_chan.green)
                        + SUM_W'(req_chan.blue);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= in_acc;
      end
   end

   for (genvar k = 0; k < CW; k++) begin : g_div
      logic [REM_W:0]   cur_r, cur_g;
      logic             bit_r, bit_g;
      logic [REM_W:0]   nrem_r, nrem_g;
      logic [CW-1:0]    quo_r_in, quo_g_in;

      // first step takes the channel value itself, later ones the doubled remainder
      if (k == 0) begin : g_first
         assign cur_r    = {1'b0, rem_r_ff[k]};
         assign cur_g    = {1'b0, rem_g_ff[k]};
         assign quo_r_in = {{(CW-1){1'b0}}, bit_r};
         assign quo_g_in = {{(CW-1){1'b0}}, bit_g};
      end else begin : g_next
         assign cur_r    = {rem_r_ff[k], 1'b0};
         assign cur_g    = {rem_g_ff[k], 1'b0};
         assign quo_r_in = {quo_r_ff[k][CW-2:0], bit_r};
         assign quo_g_in = {quo_g_ff[k][CW-2:0], bit_g};
      end

      // compare and subtract, one quotient bit per stage
      assign bit_r  = cur_r >= {1'b0, sum_ff[k]};
      assign bit_g  = cur_g >= {1'b0, sum_ff[k]};
      assign nrem_r = bit_r ? cur_r - {1'b0, sum_ff[k]} : cur_r;
      assign nrem_g = bit_g ? cur_g - {1'b0, sum_ff[k]} : cur_g;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_r_ff[k+1] <= nrem_r[REM_W-1:0];
            rem_g_ff[k+1] <= nrem_g[REM_W-1:0];
            quo_r_ff[k+1] <= quo_r_in;
            quo_g_ff[k+1] <= quo_g_in;
            sum_ff[k+1]   <= sum_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end
   end

   // deviation from the model mean
   logic signed [DW-1:0] dev_r_in, dev_g_in, dev_r_ff, dev_g_ff;
   logic [CW-1:0]        cr_dev_ff, cg_dev_ff;
   logic                 blk_dev_ff, v_dev_ff;

   assign dev_r_in = $signed({1'b0, quo_r_ff[CW]}) - $signed({1'b0, mean_r_ff});
   assign dev_g_in = $signed({1'b0, quo_g_ff[CW]}) - $signed({1'b0, mean_g_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         dev_r_ff   <= dev_r_in;
         dev_g_ff   <= dev_g_in;
         cr_dev_ff  <= quo_r_ff[CW];
         cg_dev_ff  <= quo_g_ff[CW];
         blk_dev_ff <= sum_ff[CW] == '0;
      end
   end

   // deviation products: rr, rg, gg
   logic signed [PW-1:0] sq_in [3];
   logic signed [PW-1:0] sq_ff [3];
   logic [CW-1:0]        cr_sq_ff, cg_sq_ff;
   logic                 blk_sq_ff, v_sq_ff;

   assign sq_in[0] = PW'(dev_r_ff) * PW'(dev_r_ff);
   assign sq_in[1] = PW'(dev_r_ff) * PW'(dev_g_ff);
   assign sq_in[2] = PW'(dev_g_ff) * PW'(dev_g_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff     <= sq_in;
         cr_sq_ff  <= cr_dev_ff;
         cg_sq_ff  <= cg_dev_ff;
         blk_sq_ff <= blk_dev_ff;
      end
   end

   // weight by the coefficients, each product split into two slices
   logic signed [COEF_W-1:0] coef_sel [3];
   logic signed [LP_W-1:0]   lo_p_in [3];
   logic signed [HP_W-1:0]   hi_p_in [3];
   logic signed [LP_W-1:0]   lo_p_ff [3];
   logic signed [HP_W-1:0]   hi_p_ff [3];
   logic [CW-1:0]            cr_pp_ff, cg_pp_ff;
   logic                     blk_pp_ff, v_pp_ff;

   assign coef_sel[0] = coef_rr_ff;
   assign coef_sel[1] = coef_rg_ff;
   assign coef_sel[2] = coef_gg_ff;

   always_comb begin
      logic signed [LO_W:0]   lo_s;
      logic signed [HI_W-1:0] hi_s;
      for (int i = 0; i < 3; i++) begin
         lo_s       = $signed({1'b0, sq_ff[i][LO_W-1:0]});
         hi_s       = $signed(sq_ff[i][PW-1:LO_W]);
         lo_p_in[i] = LP_W'(lo_s) * LP_W'(coef_sel[i]);
         hi_p_in[i] = HP_W'(hi_s) * HP_W'(coef_sel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_p_ff   <= lo_p_in;
         hi_p_ff   <= hi_p_in;
         cr_pp_ff  <= cr_sq_ff;
         cg_pp_ff  <= cg_sq_ff;
         blk_pp_ff <= blk_sq_ff;
      end
   end

   // rejoin the slices into full terms
   logic signed [TW-1:0] term_in [3];
   logic signed [TW-1:0] term_ff [3];
   logic [CW-1:0]        cr_tm_ff, cg_tm_ff;
   logic                 blk_tm_ff, v_tm_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = (TW'(hi_p_ff[i]) <<< LO_W) + TW'(lo_p_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff   <= term_in;
         cr_tm_ff  <= cr_pp_ff;
         cg_tm_ff  <= cg_pp_ff;
         blk_tm_ff <= blk_pp_ff;
      end
   end

   // sum of the three terms
   logic signed [AW-1:0] acc_in, acc_ff;
   logic [CW-1:0]        cr_acc_ff, cg_acc_ff;
   logic                 blk_acc_ff, v_acc_ff;

   assign acc_in = AW'(term_ff[0]) + AW'(term_ff[1]) + AW'(term_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff     <= acc_in;
         cr_acc_ff  <= cr_tm_ff;
         cg_acc_ff  <= cg_tm_ff;
         blk_acc_ff <= blk_tm_ff;
      end
   end

   // floor to the score scale; deviations are bounded so the score never
   // reaches the 48-bit limits, and no clamping is done
   logic signed [SCORE_W-1:0] score_in;
   logic                      match_in;
   logic [CW-1:0]             rsp_cr_ff, rsp_cg_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic                      rsp_match_ff, rsp_vres_ff;

   assign score_in = SCORE_W'(acc_ff >>> SHIFT);
   assign match_in = score_in > thr_ff;

   // output register, black pixels report all zero
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_cr_ff    <= blk_acc_ff ? '0 : cr_acc_ff;
         rsp_cg_ff    <= blk_acc_ff ? '0 : cg_acc_ff;
         rsp_score_ff <= blk_acc_ff ? '0 : score_in;
         rsp_match_ff <= !blk_acc_ff && match_in;
         rsp_vres_ff  <= !blk_acc_ff;
      end
   end

   // valid bits of the post-divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v_dev_ff <= 1'b0;
         v_sq_ff  <= 1'b0;
         v_pp_ff  <= 1'b0;
         v_tm_ff  <= 1'b0;
         v_acc_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         v_dev_ff <= dv_ff[CW];
         v_sq_ff  <= v_dev_ff;
         v_pp_ff  <= v_sq_ff;
         v_tm_ff  <= v_pp_ff;
         v_acc_ff <= v_tm_ff;
         rsp_v_ff <= v_acc_ff;
      end
   end

   assign rsp_chan.valid     = rsp_v_ff;
   assign rsp_chan.chroma_r  = rsp_cr_ff;
   assign rsp_chan.chroma_g  = rsp_cg_ff;
   assign rsp_chan.score     = rsp_score_ff;
   assign rsp_chan.match     = rsp_match_ff;
   assign rsp_chan.valid_res = rsp_vres_ff;

endmodule
